### rtl/aapr_pkg.sv
// Shared constants for the axis-angle point rotator: CORDIC table and gain,
// fixed-point formats of the rotation unit and configuration register indexes.
// No dependencies.
`timescale 1ns / 1ps

package aapr_pkg;

	// CORDIC works in Q1.30, angle unit 2^32 = full turn
	localparam int CORDIC_FRAC  = 30;
	localparam int CORDIC_STEPS = 24;
	localparam int CORDIC_XW    = 34;
	localparam int CORDIC_ZW    = 33;
	localparam int STEP_W       = 5;
	localparam logic signed [CORDIC_XW-1:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic [29:0] CORDIC_ATAN [0:CORDIC_STEPS-1] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
		30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
		30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
		30'd166886,    30'd83443,     30'd41722,     30'd20861,
		30'd10430,     30'd5215,      30'd2608,      30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81
	};

	// axis components are Q1.14, angle is a 16-bit turn fraction
	localparam int AXIS_W    = 16;
	localparam int AXIS_FRAC = 14;
	localparam int ANGLE_W   = 16;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AXIS_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT    = 3'd7;

endpackage

### rtl/axis_angle_point_rotation.sv
// Axis-angle point rotator: matrix build unit (CORDIC plus Euler-Rodrigues terms)
// and a four-stage point pipeline ending in an output register.
// Depends on aapr_pkg.
`timescale 1ns / 1ps

// Rotates Q16.16 points about the configured axis and center. Every write to a
// register index 0..6 rebuilds the 3x3 matrix: a load state, 24 CORDIC steps on
// one shared step unit, then a state each for the half-angle terms, their products
// and the rounded, saturated entries; in_ready is low throughout. Before the
// first write the matrix is zero and every point maps onto the center. Once
// built, the point pipeline takes one transaction per cycle while the output
// is not stalled and passes it through center subtract, nine multipliers,
// column sums with rounding and saturation into the output register. A stall on
// the output side backs up through the stages without losing or repeating items.
module axis_angle_point_rotation import aapr_pkg::*; #(
	parameter int COORD_WIDTH    = 32,
	parameter int COEF_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_IDX_W-1:0]          cfg_index,
	input  logic [COORD_WIDTH-1:0]        cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] init_x,
	input  logic signed [COORD_WIDTH-1:0] init_y,
	input  logic signed [COORD_WIDTH-1:0] init_z,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] new_x,
	output logic signed [COORD_WIDTH-1:0] new_y,
	output logic signed [COORD_WIDTH-1:0] new_z,
	output logic signed [COORD_WIDTH-1:0] disp_x,
	output logic signed [COORD_WIDTH-1:0] disp_y,
	output logic signed [COORD_WIDTH-1:0] disp_z
);

	localparam int CW    = COEF_FRAC_BITS + 4;        // entry width and working fraction
	localparam int AW    = CW + 3;                    // a, b, c, d
	localparam int PRW   = 2 * AW;
	localparam int EW    = PRW + 2;
	localparam int BPW   = AXIS_W + CORDIC_XW;
	localparam int SH_A  = CORDIC_FRAC - CW;
	localparam int SH_B  = CORDIC_FRAC + AXIS_FRAC - CW;
	localparam int SH_E  = 2 * CW - COEF_FRAC_BITS;
	localparam int CEN_W = COORD_WIDTH + 1;
	localparam int PW    = CEN_W + CW;
	localparam int SW    = PW + 2;
	localparam int RW    = SW + 1;

	localparam logic signed [CORDIC_XW-1:0] A_HALF = CORDIC_XW'(64'd1 << (SH_A - 1));
	localparam logic signed [BPW-1:0]       B_HALF = BPW'(64'd1 << (SH_B - 1));
	localparam logic signed [EW-1:0]        E_HALF = EW'(64'd1 << (SH_E - 1));
	localparam logic signed [SW-1:0]        P_HALF = SW'(64'd1 << (COEF_FRAC_BITS - 1));

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_ROT  = 3'd2;
	localparam logic [2:0] ST_ABCD = 3'd3;
	localparam logic [2:0] ST_PROD = 3'd4;
	localparam logic [2:0] ST_SUM  = 3'd5;

	function automatic logic signed [CW-1:0] sat_coef(input logic signed [EW-1:0] v);
		logic ok;
		ok = (&v[EW-1:CW-1]) || !(|v[EW-1:CW-1]);
		return ok ? v[CW-1:0] : {v[EW-1], {(CW-1){~v[EW-1]}}};
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(input logic signed [RW-1:0] v);
		logic ok;
		ok = (&v[RW-1:COORD_WIDTH-1]) || !(|v[RW-1:COORD_WIDTH-1]);
		return ok ? v[COORD_WIDTH-1:0] : {v[RW-1], {(COORD_WIDTH-1){~v[RW-1]}}};
	endfunction

	// configuration registers
	logic signed [AXIS_W-1:0]      axis_q [3];
	logic [ANGLE_W-1:0]            angle_q;
	logic signed [COORD_WIDTH-1:0] center_q [3];
	logic                          cfg_hit;

	assign cfg_hit = cfg_we && (cfg_index < REG_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q[0]   <= '0;
			axis_q[1]   <= '0;
			axis_q[2]   <= AXIS_W'(16'sd16384);
			angle_q     <= '0;
			center_q[0] <= '0;
			center_q[1] <= '0;
			center_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS_X:   axis_q[0]   <= cfg_data[AXIS_W-1:0];
				REG_AXIS_Y:   axis_q[1]   <= cfg_data[AXIS_W-1:0];
				REG_AXIS_Z:   axis_q[2]   <= cfg_data[AXIS_W-1:0];
				REG_ANGLE:    angle_q     <= cfg_data[ANGLE_W-1:0];
				REG_CENTER_X: center_q[0] <= cfg_data;
				REG_CENTER_Y: center_q[1] <= cfg_data;
				REG_CENTER_Z: center_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// matrix build unit
	logic [2:0]                    bld_state_q;
	logic [STEP_W-1:0]             step_q;
	logic signed [CW-1:0]          mat_q [9];
	logic signed [CORDIC_XW-1:0]   x_q, y_q;
	logic signed [CORDIC_ZW-1:0]   z_q;
	logic                          flip_q;
	logic signed [AW-1:0]          a_q, b_q, c_q, d_q;
	logic signed [PRW-1:0]         pr_q [10];

	logic [ANGLE_W:0]              ang_eff;
	logic signed [CORDIC_XW-1:0]   dx, dy, x_fin, a_full;
	logic signed [CORDIC_ZW-1:0]   atan_ext;
	logic signed [BPW-1:0]         bprod [3];
	logic signed [BPW-1:0]         bround [3];
	logic signed [EW-1:0]          e [9];
	logic signed [EW-1:0]          e_rnd [9];

	always_comb begin
		ang_eff  = angle_q[ANGLE_W-1] ? (17'h10000 - {1'b0, angle_q}) : {1'b0, angle_q};
		dx       = y_q >>> step_q;
		dy       = x_q >>> step_q;
		atan_ext = $signed({3'b000, CORDIC_ATAN[step_q]});
		x_fin    = flip_q ? -x_q : x_q;
		a_full   = (x_fin + A_HALF) >>> SH_A;
		for (int k = 0; k < 3; k++) begin
			bprod[k]  = axis_q[k] * y_q;
			bround[k] = (bprod[k] + B_HALF) >>> SH_B;
		end
		// pr order: aa bb cc dd bc ad bd ac cd ab
		e[0] = EW'(pr_q[0]) + EW'(pr_q[1]) - EW'(pr_q[2]) - EW'(pr_q[3]);
		e[1] = (EW'(pr_q[4]) - EW'(pr_q[5])) <<< 1;
		e[2] = (EW'(pr_q[6]) + EW'(pr_q[7])) <<< 1;
		e[3] = (EW'(pr_q[4]) + EW'(pr_q[5])) <<< 1;
		e[4] = EW'(pr_q[0]) + EW'(pr_q[2]) - EW'(pr_q[1]) - EW'(pr_q[3]);
		e[5] = (EW'(pr_q[8]) - EW'(pr_q[9])) <<< 1;
		e[6] = (EW'(pr_q[6]) - EW'(pr_q[7])) <<< 1;
		e[7] = (EW'(pr_q[8]) + EW'(pr_q[9])) <<< 1;
		e[8] = EW'(pr_q[0]) + EW'(pr_q[3]) - EW'(pr_q[1]) - EW'(pr_q[2]);
		for (int k = 0; k < 9; k++) begin
			e_rnd[k] = (e[k] + E_HALF) >>> SH_E;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bld_state_q <= ST_IDLE;
			step_q      <= '0;
			for (int k = 0; k < 9; k++) begin
				mat_q[k] <= '0;
			end
		end else if (cfg_hit) begin
			// restart on every write to index 0..6 so the matrix follows the latest registers
			bld_state_q <= ST_LOAD;
		end else begin
			case (bld_state_q)
				ST_IDLE: ;
				ST_LOAD: begin
					bld_state_q <= ST_ROT;
					step_q      <= '0;
				end
				ST_ROT: begin
					if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
						bld_state_q <= ST_ABCD;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_ABCD: bld_state_q <= ST_PROD;
				ST_PROD: bld_state_q <= ST_SUM;
				ST_SUM: begin
					for (int k = 0; k < 9; k++) begin
						mat_q[k] <= sat_coef(e_rnd[k]);
					end
					bld_state_q <= ST_IDLE;
				end
				default: bld_state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (bld_state_q)
			ST_LOAD: begin
				flip_q <= angle_q[ANGLE_W-1];
				x_q    <= CORDIC_GAIN;
				y_q    <= '0;
				z_q    <= $signed({1'b0, ang_eff, 15'b0});
			end
			ST_ROT: begin
				if (!z_q[CORDIC_ZW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - atan_ext;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + atan_ext;
				end
			end
			ST_ABCD: begin
				a_q <= a_full[AW-1:0];
				b_q <= -bround[0][AW-1:0];
				c_q <= -bround[1][AW-1:0];
				d_q <= -bround[2][AW-1:0];
			end
			ST_PROD: begin
				pr_q[0] <= a_q * a_q;
				pr_q[1] <= b_q * b_q;
				pr_q[2] <= c_q * c_q;
				pr_q[3] <= d_q * d_q;
				pr_q[4] <= b_q * c_q;
				pr_q[5] <= a_q * d_q;
				pr_q[6] <= b_q * d_q;
				pr_q[7] <= a_q * c_q;
				pr_q[8] <= c_q * d_q;
				pr_q[9] <= a_q * b_q;
			end
			default: ;
		endcase
	end

	// point pipeline
	logic                          v_s1, v_s2, v_s3;
	logic                          en1, en2, en3, en_o;
	logic                          in_acc;
	logic signed [COORD_WIDTH-1:0] in_p [3];
	logic signed [CEN_W-1:0]       cen_s1 [3];
	logic signed [COORD_WIDTH-1:0] p_s1 [3], p_s2 [3], p_s3 [3];
	logic signed [PW-1:0]          prod_s2 [9];
	logic signed [RW-1:0]          r_s3 [3];
	logic signed [SW-1:0]          col_sum [3];
	logic signed [SW-1:0]          col_rnd [3];
	logic signed [RW-1:0]          disp_full [3];
	logic                          out_valid_q;
	logic signed [COORD_WIDTH-1:0] new_q [3], disp_q [3];

	assign in_p[0] = init_x;
	assign in_p[1] = init_y;
	assign in_p[2] = init_z;

	assign en_o     = !out_valid_q || out_ready;
	assign en3      = !v_s3 || en_o;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1 && (bld_state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			col_sum[j] = SW'(prod_s2[j]) + SW'(prod_s2[3 + j]) + SW'(prod_s2[6 + j]);
			col_rnd[j] = (col_sum[j] + P_HALF) >>> COEF_FRAC_BITS;
			disp_full[j] = r_s3[j] - RW'(p_s3[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_acc;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en_o) out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int k = 0; k < 3; k++) begin
				cen_s1[k] <= CEN_W'(in_p[k]) - CEN_W'(center_q[k]);
				p_s1[k]   <= in_p[k];
			end
		end
		if (en2) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i * 3 + j] <= cen_s1[i] * mat_q[i * 3 + j];
				end
			end
			p_s2 <= p_s1;
		end
		if (en3) begin
			for (int j = 0; j < 3; j++) begin
				r_s3[j] <= RW'(col_rnd[j]) + RW'(center_q[j]);
			end
			p_s3 <= p_s2;
		end
		if (en_o) begin
			for (int j = 0; j < 3; j++) begin
				new_q[j]  <= sat_coord(r_s3[j]);
				disp_q[j] <= sat_coord(disp_full[j]);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign new_x     = new_q[0];
	assign new_y     = new_q[1];
	assign new_z     = new_q[2];
	assign disp_x    = disp_q[0];
	assign disp_y    = disp_q[1];
	assign disp_z    = disp_q[2];

	// no point enters while the matrix is being rebuilt
	a_no_accept_in_build: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (bld_state_q == ST_IDLE))
		else $error("point accepted during matrix build");

	a_write_starts_build: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> (bld_state_q == ST_LOAD))
		else $error("register write did not restart matrix build");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> v_s1)
		else $error("accepted transaction missing from first stage");

	a_stall_holds_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !en3) |=> (v_s3 && $stable(r_s3[0])))
		else $error("stalled stage lost its transaction");

endmodule

### sim/axis_angle_point_rotation_test.sv
// Testbench for the axis-angle point rotator: directed and random points under several
// rotation settings, with random gaps on both channels and an independent predictor.
// Depends on aapr_pkg and axis_angle_point_rotation.
`timescale 1ns / 1ps

module axis_angle_point_rotation_test;
	import aapr_pkg::*;

	localparam int CW = 32;
	localparam int CFB = 16;
	localparam int WF = CFB + 4;
	localparam longint CYCLE_LIMIT = 800000;
	localparam longint ATAN [0:23] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81
	};

	typedef struct {
		logic signed [CW-1:0] nx, ny, nz, dx, dy, dz;
	} rotated_point_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CW-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [CW-1:0] init_x = '0, init_y = '0, init_z = '0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [CW-1:0] new_x, new_y, new_z, disp_x, disp_y, disp_z;

	// predictor state
	longint axis_v [3];
	longint angle_v;
	longint center_v [3];
	longint coef [9];

	rotated_point_t pending_points [$];
	int mismatches = 0;
	longint cycles = 0;
	bit quiet = 0;
	int stall_left = 0;

	axis_angle_point_rotation #(.COORD_WIDTH(CW), .COEF_FRAC_BITS(CFB)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready),
		.init_x(init_x), .init_y(init_y), .init_z(init_z), .out_valid(out_valid),
		.out_ready(out_ready), .new_x(new_x), .new_y(new_y), .new_z(new_z),
		.disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic longint round_half_up(longint v, int n);
		return (v + (longint'(1) << (n - 1))) >>> n;
	endfunction

	function automatic longint clamp(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic void rebuild_coefs();
		longint ang, z, x, y, ddx, ddy, a, b, c, d;
		longint e [9];
		bit flip;
		ang = angle_v & 'hFFFF;
		flip = ang >= 32768;
		z = (flip ? 65536 - ang : ang) << 15;
		x = 652032874;
		y = 0;
		for (int i = 0; i < 24; i++) begin
			ddx = y >>> i;
			ddy = x >>> i;
			if (z >= 0) begin
				x -= ddx; y += ddy; z -= ATAN[i];
			end else begin
				x += ddx; y -= ddy; z += ATAN[i];
			end
		end
		if (flip)
			x = -x;
		a = round_half_up(x, 30 - WF);
		b = -round_half_up(axis_v[0] * y, 44 - WF);
		c = -round_half_up(axis_v[1] * y, 44 - WF);
		d = -round_half_up(axis_v[2] * y, 44 - WF);
		e[0] = a*a + b*b - c*c - d*d;
		e[1] = 2 * (b*c - a*d);
		e[2] = 2 * (b*d + a*c);
		e[3] = 2 * (b*c + a*d);
		e[4] = a*a + c*c - b*b - d*d;
		e[5] = 2 * (c*d - a*b);
		e[6] = 2 * (b*d - a*c);
		e[7] = 2 * (c*d + a*b);
		e[8] = a*a + d*d - b*b - c*c;
		for (int i = 0; i < 9; i++)
			coef[i] = clamp(round_half_up(e[i], 2 * WF - CFB), CFB + 4);
	endfunction

	function automatic rotated_point_t rotate_point(logic signed [CW-1:0] px,
			logic signed [CW-1:0] py, logic signed [CW-1:0] pz);
		longint p [3], hi [3], lo [3], cen, h, l, r;
		longint nv [3], dv [3];
		rotated_point_t res;
		p[0] = longint'(px); p[1] = longint'(py); p[2] = longint'(pz);
		for (int i = 0; i < 3; i++) begin
			cen = p[i] - center_v[i];
			hi[i] = cen >>> 24;
			lo[i] = cen - (hi[i] << 24);
		end
		for (int j = 0; j < 3; j++) begin
			h = 0;
			l = 0;
			for (int i = 0; i < 3; i++) begin
				h += hi[i] * coef[i*3 + j];
				l += lo[i] * coef[i*3 + j];
			end
			l += longint'(1) << (CFB - 1);
			r = h * (longint'(1) << (24 - CFB)) + (l >>> CFB) + center_v[j];
			nv[j] = clamp(r, CW);
			dv[j] = clamp(r - p[j], CW);
		end
		res.nx = CW'(nv[0]); res.ny = CW'(nv[1]); res.nz = CW'(nv[2]);
		res.dx = CW'(dv[0]); res.dy = CW'(dv[1]); res.dz = CW'(dv[2]);
		return res;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(99);
		if (r < 70)
			return 0;
		if (r < 95)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: random stalls, some long
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 0;
			stall_left <= stall_left - 1;
		end else if (quiet || $urandom_range(99) < 80) begin
			out_ready <= 1;
		end else begin
			out_ready <= 0;
			stall_left <= ($urandom_range(19) == 0) ? $urandom_range(60, 20) :
				$urandom_range(2, 0);
		end
	end

	// compare each result transaction with the oldest expected point; sample
	// mid-cycle so the values are those seen at the next accepting edge
	always @(negedge clk) begin
		rotated_point_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: new %0d %0d %0d", new_x, new_y, new_z);
			end else begin
				want = pending_points.pop_front();
				if (want.nx !== new_x || want.ny !== new_y || want.nz !== new_z ||
						want.dx !== disp_x || want.dy !== disp_y || want.dz !== disp_z) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: new exp %0d %0d %0d got %0d %0d %0d; ",
							want.nx, want.ny, want.nz, new_x, new_y, new_z,
							"disp exp %0d %0d %0d got %0d %0d %0d",
							want.dx, want.dy, want.dz, disp_x, disp_y, disp_z);
				end
			end
		end
	end

	task automatic send_point(logic signed [CW-1:0] px, logic signed [CW-1:0] py,
			logic signed [CW-1:0] pz);
		int gap;
		bit rdy;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		init_x <= px;
		init_y <= py;
		init_z <= pz;
		// sample ready mid-cycle, then step to the edge that it governs
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		pending_points.push_back(rotate_point(px, py, pz));
	endtask

	// hold the sender and let every expected result drain
	task automatic drain();
		in_valid <= 0;
		while (pending_points.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == REG_AXIS_X || idx == REG_AXIS_Y || idx == REG_AXIS_Z)
			axis_v[idx] = longint'($signed(val[15:0]));
		else if (idx == REG_ANGLE)
			angle_v = longint'(val[15:0]);
		else if (idx != REG_COUNT)
			center_v[idx - REG_CENTER_X] = longint'($signed(val));
		if (idx != REG_COUNT)
			rebuild_coefs();
		// let the matrix rebuild finish
		repeat (32) @(posedge clk);
	endtask

	task automatic set_rotation(int ax, int ay, int az, int ang, int cx, int cy, int cz);
		write_reg(REG_AXIS_X, ax);
		write_reg(REG_AXIS_Y, ay);
		write_reg(REG_AXIS_Z, az);
		write_reg(REG_ANGLE, ang);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		write_reg(REG_CENTER_Z, cz);
	endtask

	function automatic logic [CW-1:0] random_coord();
		int r;
		r = $urandom_range(9);
		if (r < 6)
			return $signed($urandom_range(2 << 20)) - (1 << 20);
		if (r < 9)
			return $urandom;
		return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
	endfunction

	task automatic send_extremes();
		send_point(0, 0, 0);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
		send_point(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
	endtask

	// points before any write land on the center
	task automatic test_zero_matrix();
		send_extremes();
		drain();
	endtask

	task automatic test_directed_settings();
		set_rotation(0, 0, 16384, 16384, 0, 0, 0);
		send_extremes();
		drain();
		write_reg(REG_ANGLE, 32768);
		send_extremes();
		drain();
		set_rotation(16384, 0, 0, 65535, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000);
		send_extremes();
		drain();
		// non-unit axis, whose matrix entries stay inside the saturation range
		set_rotation(-16384, -16384, 16384, 32767, 0, 0, 0);
		send_extremes();
		drain();
		// out-of-range index leaves the matrix alone
		write_reg(REG_COUNT, 32'hFFFF_FFFF);
		send_point(32'h0003_0000, 32'hFFFD_0000, 32'h1234_5678);
		drain();
		write_reg(REG_ANGLE, 0);
		send_point(32'h0003_0000, 32'hFFFD_0000, 32'h1234_5678);
		drain();
	endtask

	task automatic test_random_stream();
		int ax, ay, az;
		for (int phase = 0; phase < 8; phase++) begin
			ax = $signed($urandom_range(32768)) - 16384;
			ay = $signed($urandom_range(32768)) - 16384;
			az = $signed($urandom_range(32768)) - 16384;
			if (phase == 0) begin
				ax = 0; ay = 16384; az = 0;
			end
			set_rotation(ax, ay, az, $urandom_range(65535),
				random_coord(), random_coord(), random_coord());
			quiet = (phase == 3);
			for (int n = 0; n < 220; n++) begin
				send_point(random_coord(), random_coord(), random_coord());
				if (phase == 5 && n == 100)
					drain();
			end
			quiet = 0;
			drain();
		end
	endtask

	initial begin
		axis_v[0] = 0; axis_v[1] = 0; axis_v[2] = 16384;
		angle_v = 0;
		for (int i = 0; i < 3; i++)
			center_v[i] = 0;
		for (int i = 0; i < 9; i++)
			coef[i] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);
		test_zero_matrix();
		test_directed_settings();
		test_random_stream();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_points.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
